[rtl/dual_line_serial_adc_reader_defines.svh]
// Assertion macros shared by the dual-line ADC reader RTL.
`ifndef DUAL_LINE_SERIAL_ADC_READER_DEFINES_SVH
`define DUAL_LINE_SERIAL_ADC_READER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DLSAR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DLSAR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dlsar_pkg.sv]
// Types and constants for the dual-line serial ADC reader.
`default_nettype none

package dlsar_pkg;

    // Output code and pair index widths
    localparam int CODE_W = 18;
    localparam int IDX_W  = 2;

    // APB register map
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_SAMPLE_PERIOD  = 3'd0;
    localparam logic [2:0] REG_SAMPLE_COUNT   = 3'd1;
    localparam logic [2:0] REG_CHANNELS       = 3'd2;
    localparam logic [2:0] REG_CONVERT_LOW    = 3'd3;
    localparam logic [2:0] REG_CONVERT_SETTLE = 3'd4;

    // Register reset values
    localparam logic [31:0] RST_SAMPLE_PERIOD  = 32'd100000;
    localparam logic [15:0] RST_SAMPLE_COUNT   = 16'd1;
    localparam logic [2:0]  RST_CHANNELS       = 3'd3;
    localparam logic [7:0]  RST_CONVERT_LOW    = 8'd2;
    localparam logic [7:0]  RST_CONVERT_SETTLE = 8'd2;

    // Controller phases
    typedef enum logic [6:0] {
        PH_IDLE        = 7'b0000001,
        PH_CONV_LOW    = 7'b0000010,
        PH_SETTLE      = 7'b0000100,
        PH_WAIT_BUSY   = 7'b0001000,
        PH_CLK_LOW     = 7'b0010000,
        PH_CLK_HIGH    = 7'b0100000,
        PH_WAIT_PERIOD = 7'b1000000
    } phase_t;

endpackage

`default_nettype wire

[rtl/dual_line_serial_adc_reader.sv]
// Dual-line serial ADC readout controller, one pin-level tick per transfer.
//
// Usage:
//   Each input transfer (start_req, busy_req, dout_a, dout_b) is one tick of
//   the converter interface; each tick yields exactly one output transfer
//   with the pin drives (convert_n, select_n, serial_clock), a finished code
//   pair when code_valid is high, and the running flag.
//   The result of a tick is in the output register in the cycle after its
//   input transfer. Throughput: one tick per cycle when not stalled; the
//   controller state and the output register both update in the cycle of the transfer.
//   Stall: when the receiver holds out_ready low with a result pending,
//   in_ready drops and the controller holds its state until the result is
//   taken; no tick is lost or repeated.
//   Reset: rst_n clears the phase to idle, all counters and shift registers,
//   restores the register defaults and empties the output register.
//   Configuration: APB writes at byte address 4*i, written while idle.
//   A start request in idle begins a run of sample_count conversions.
`default_nettype none
`include "dual_line_serial_adc_reader_defines.svh"

module dual_line_serial_adc_reader
    import dlsar_pkg::*;
#(
    parameter int CODE_BITS = 18,
    parameter int MAX_PAIRS = 4
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // APB configuration port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [ADDR_W-1:0]        paddr,
    input  wire logic [DATA_W-1:0]        pwdata,
    output logic      [DATA_W-1:0]        prdata,
    output logic                          pready,
    // input tick channel
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     start_req,
    input  wire logic                     busy_req,
    input  wire logic                     dout_a,
    input  wire logic                     dout_b,
    // output tick channel
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          convert_n,
    output logic                          select_n,
    output logic                          serial_clock,
    output logic                          code_valid,
    output logic        [IDX_W-1:0]       channel_index,
    output logic signed [CODE_W-1:0]      code_a,
    output logic signed [CODE_W-1:0]      code_b,
    output logic                          last_of_sample,
    output logic                          running
);

    localparam int BIT_W  = $clog2(CODE_BITS + 1);
    localparam int PAIR_W = $clog2(MAX_PAIRS + 1);
    localparam int PC_W   = ((PAIR_W > 3) ? PAIR_W : 3) + 1;

    // configuration registers
    logic [31:0] sample_period_reg;
    logic [15:0] sample_count_reg;
    logic [2:0]  channels_reg;
    logic [7:0]  convert_low_reg;
    logic [7:0]  convert_settle_reg;

    // controller state
    phase_t                 phase_reg, phase_next;
    logic [31:0]            period_cnt_reg, period_cnt_next, period_inc;
    logic [15:0]            conv_done_reg, conv_done_next;
    logic [7:0]             wait_cnt_reg, wait_cnt_next;
    logic [BIT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [PAIR_W-1:0]      pair_cnt_reg, pair_cnt_next;
    logic [CODE_BITS-1:0]   shift_a_reg, shift_a_next;
    logic [CODE_BITS-1:0]   shift_b_reg, shift_b_next;

    // output register
    logic                   out_valid_reg;
    logic                   convert_n_reg, select_n_reg, sclk_reg;
    logic                   code_valid_reg, code_valid_next;
    logic [IDX_W-1:0]       index_reg, index_next;
    logic signed [CODE_W-1:0] code_a_reg, code_a_next;
    logic signed [CODE_W-1:0] code_b_reg, code_b_next;
    logic                   last_reg, last_next;
    logic                   running_reg;

    // effective register values
    logic [31:0]            period_eff;
    logic [15:0]            count_eff;
    logic [7:0]             low_eff, settle_eff;
    logic [PC_W-1:0]        chan_eff, pairs_used, pair_plus;
    logic [PAIR_W+1:0]      pair_ext;
    logic                   in_fire;
    logic                   apb_write;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;

    assign period_eff = (sample_period_reg == 32'd0) ? 32'd1 : sample_period_reg;
    assign count_eff  = (sample_count_reg == 16'd0) ? 16'd1 : sample_count_reg;
    assign low_eff    = (convert_low_reg == 8'd0) ? 8'd1 : convert_low_reg;
    assign settle_eff = (convert_settle_reg == 8'd0) ? 8'd1 : convert_settle_reg;
    assign chan_eff   = (channels_reg == 3'd0) ? PC_W'(1) : PC_W'(channels_reg);
    assign pairs_used = (chan_eff > PC_W'(MAX_PAIRS)) ? PC_W'(MAX_PAIRS) : chan_eff;
    assign pair_plus  = PC_W'(pair_cnt_reg) + PC_W'(1);
    assign pair_ext   = {2'b00, pair_cnt_reg};

    // period counter runs (saturating) whenever a run is active
    assign period_inc = (phase_reg != PH_IDLE && period_cnt_reg != 32'hFFFF_FFFF)
                        ? period_cnt_reg + 32'd1 : period_cnt_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg  <= RST_SAMPLE_PERIOD;
            sample_count_reg   <= RST_SAMPLE_COUNT;
            channels_reg       <= RST_CHANNELS;
            convert_low_reg    <= RST_CONVERT_LOW;
            convert_settle_reg <= RST_CONVERT_SETTLE;
        end
        else if (apb_write)
        begin
            case (paddr[4:2])
                REG_SAMPLE_PERIOD:  sample_period_reg  <= pwdata;
                REG_SAMPLE_COUNT:   sample_count_reg   <= pwdata[15:0];
                REG_CHANNELS:       channels_reg       <= pwdata[2:0];
                REG_CONVERT_LOW:    convert_low_reg    <= pwdata[7:0];
                REG_CONVERT_SETTLE: convert_settle_reg <= pwdata[7:0];
                default:            ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (paddr[4:2])
            REG_SAMPLE_PERIOD:  prdata = sample_period_reg;
            REG_SAMPLE_COUNT:   prdata = {16'd0, sample_count_reg};
            REG_CHANNELS:       prdata = {29'd0, channels_reg};
            REG_CONVERT_LOW:    prdata = {24'd0, convert_low_reg};
            REG_CONVERT_SETTLE: prdata = {24'd0, convert_settle_reg};
            default:            prdata = '0;
        endcase
    end

    // next state and result of one tick
    always_comb
    begin
        phase_next      = phase_reg;
        period_cnt_next = period_inc;
        conv_done_next  = conv_done_reg;
        wait_cnt_next   = wait_cnt_reg;
        bit_cnt_next    = bit_cnt_reg;
        pair_cnt_next   = pair_cnt_reg;
        shift_a_next    = shift_a_reg;
        shift_b_next    = shift_b_reg;
        code_valid_next = 1'b0;
        index_next      = '0;
        code_a_next     = '0;
        code_b_next     = '0;
        last_next       = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (start_req)
                begin
                    period_cnt_next = '0;
                    conv_done_next  = '0;
                    wait_cnt_next   = 8'd1;
                    phase_next      = PH_CONV_LOW;
                end
            end
            PH_CONV_LOW:
            begin
                if (wait_cnt_reg >= low_eff)
                begin
                    wait_cnt_next = 8'd1;
                    phase_next    = PH_SETTLE;
                end
                else
                begin
                    wait_cnt_next = wait_cnt_reg + 8'd1;
                end
            end
            PH_SETTLE:
            begin
                if (wait_cnt_reg >= settle_eff)
                begin
                    wait_cnt_next = 8'd0;
                    phase_next    = PH_WAIT_BUSY;
                end
                else
                begin
                    wait_cnt_next = wait_cnt_reg + 8'd1;
                end
            end
            PH_WAIT_BUSY:
            begin
                if (!busy_req)
                begin
                    bit_cnt_next  = '0;
                    pair_cnt_next = '0;
                    shift_a_next  = '0;
                    shift_b_next  = '0;
                    phase_next    = PH_CLK_LOW;
                end
            end
            PH_CLK_LOW:
            begin
                // sample both lines, MSB first
                shift_a_next = {shift_a_reg[CODE_BITS-2:0], dout_a};
                shift_b_next = {shift_b_reg[CODE_BITS-2:0], dout_b};
                bit_cnt_next = bit_cnt_reg + BIT_W'(1);
                if (bit_cnt_next >= BIT_W'(CODE_BITS))
                begin
                    code_valid_next = 1'b1;
                    index_next      = pair_ext[1:0];
                    code_a_next     = CODE_W'($signed(shift_a_next));
                    code_b_next     = CODE_W'($signed(shift_b_next));
                    last_next       = (pair_plus >= pairs_used);
                end
                phase_next = PH_CLK_HIGH;
            end
            PH_CLK_HIGH:
            begin
                phase_next = PH_CLK_LOW;
                if (bit_cnt_reg >= BIT_W'(CODE_BITS))
                begin
                    bit_cnt_next = '0;
                    shift_a_next = '0;
                    shift_b_next = '0;
                    if (pair_plus >= pairs_used)
                    begin
                        // conversion complete
                        pair_cnt_next  = '0;
                        conv_done_next = conv_done_reg + 16'd1;
                        phase_next = (conv_done_next >= count_eff || conv_done_next == 16'd0)
                                     ? PH_IDLE : PH_WAIT_PERIOD;
                    end
                    else
                    begin
                        pair_cnt_next = PAIR_W'(pair_plus);
                    end
                end
            end
            PH_WAIT_PERIOD:
            begin
                // absolute schedule: lateness carries into the next period
                if (period_inc >= period_eff)
                begin
                    period_cnt_next = period_inc - period_eff;
                    wait_cnt_next   = 8'd1;
                    phase_next      = PH_CONV_LOW;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // controller state, advanced once per input transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            period_cnt_reg <= '0;
            conv_done_reg  <= '0;
            wait_cnt_reg   <= '0;
            bit_cnt_reg    <= '0;
            pair_cnt_reg   <= '0;
            shift_a_reg    <= '0;
            shift_b_reg    <= '0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            period_cnt_reg <= period_cnt_next;
            conv_done_reg  <= conv_done_next;
            wait_cnt_reg   <= wait_cnt_next;
            bit_cnt_reg    <= bit_cnt_next;
            pair_cnt_reg   <= pair_cnt_next;
            shift_a_reg    <= shift_a_next;
            shift_b_reg    <= shift_b_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            convert_n_reg  <= (phase_next != PH_CONV_LOW);
            select_n_reg   <= !(phase_next == PH_CLK_LOW || phase_next == PH_CLK_HIGH);
            sclk_reg       <= (phase_next != PH_CLK_LOW);
            code_valid_reg <= code_valid_next;
            index_reg      <= index_next;
            code_a_reg     <= code_a_next;
            code_b_reg     <= code_b_next;
            last_reg       <= last_next;
            running_reg    <= (phase_next != PH_IDLE);
        end
    end

    assign out_valid      = out_valid_reg;
    assign convert_n      = convert_n_reg;
    assign select_n       = select_n_reg;
    assign serial_clock   = sclk_reg;
    assign code_valid     = code_valid_reg;
    assign channel_index  = index_reg;
    assign code_a         = code_a_reg;
    assign code_b         = code_b_reg;
    assign last_of_sample = last_reg;
    assign running        = running_reg;

    // checks; a code pair lands as the serial clock returns high
    `DLSAR_ASSERT_NOW(a_phase_onehot, 1'b1, $onehot(phase_reg), "phase not one-hot")
    `DLSAR_ASSERT_NOW(a_code_in_read, out_valid && code_valid, !select_n && serial_clock && convert_n, "code outside a read")
    `DLSAR_ASSERT_NOW(a_bit_range, 1'b1, bit_cnt_reg <= BIT_W'(CODE_BITS), "bit counter overrun")
    `DLSAR_ASSERT_NOW(a_pair_range, 1'b1, PC_W'(pair_cnt_reg) < PC_W'(MAX_PAIRS), "pair counter overrun")
    `DLSAR_ASSERT_NEXT(a_idle_stays, in_fire && phase_reg == PH_IDLE && !start_req, out_valid && !running && select_n, "idle tick left idle")

endmodule

`default_nettype wire
